// ===== src/sli_pkg.sv =====
// Shared types, codes and constants for the sorted list block.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 2'd0,
    OP_REMOVE_AT    = 2'd1,
    OP_REMOVE_FIRST = 2'd2,
    OP_REMOVE_LAST  = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e_t;

  typedef struct packed {
    op_e_t                     op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } request_t;

  typedef struct packed {
    status_e_t                 status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
    logic reply;
  } ctl_cmd_t;

endpackage

// ===== src/sli_ctrl.sv =====
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps

module sli_ctrl
  import sli_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_APPLY = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // A new transaction may enter while the previous result is on the strobe.
  assign busy   = !(state == S_IDLE || state == S_REPLY);
  assign accept = start && !busy;
  assign done   = (state == S_REPLY);

  assign cmd.load  = accept;
  assign cmd.eval  = (state == S_EVAL);
  assign cmd.apply = (state == S_APPLY);
  assign cmd.reply = (state == S_REPLY);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EVAL;
      S_EVAL:  state_next = S_APPLY;
      S_APPLY: state_next = S_REPLY;
      S_REPLY: state_next = accept ? S_EVAL : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("result strobe did not follow an accepted transaction");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

endmodule

// ===== src/sli_datapath.sv =====
// Entry cells, count register and result register of the sorted list.
`timescale 1ns / 1ps

module sli_datapath
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  input  request_t request,
  output result_t  result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  request_t                  req;

  // Evaluation results, registered between the compare and the shift.
  logic [DEPTH-1:0]          lt_mask;
  logic [DEPTH-1:0]          lt_mask_next;
  logic [DEPTH-1:0]          sh_mask;
  logic [DEPTH-1:0]          sh_mask_next;
  logic                      ok;
  logic                      ok_next;
  status_e_t                 status;
  status_e_t                 status_next;
  logic signed [VALUE_W-1:0] removed;
  logic signed [VALUE_W-1:0] removed_next;
  logic [IDX_W-1:0]          idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  // Compare every cell against the new value, work out the status, and pick the shift mask and removed value.
  always_comb begin
    status_next = ST_OK;
    idx         = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lt_mask_next[i] = (32'(i) < 32'(count)) && (entries[i] < req.value);
    end
    case (req.op)
      OP_INSERT: begin
        if (32'(count) >= 32'(DEPTH)) status_next = ST_FULL;
      end
      OP_REMOVE_AT: begin
        idx = IDX_W'(req.position);
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (32'(req.position) >= 32'(count)) begin
          status_next = ST_BADPOS;
        end
      end
      OP_REMOVE_FIRST: begin
        idx = '0;
        if (count == '0) status_next = ST_EMPTY;
      end
      OP_REMOVE_LAST: begin
        idx = IDX_W'(count - CNT_W'(1));
        if (count == '0) status_next = ST_EMPTY;
      end
      default: status_next = ST_OK;
    endcase
    ok_next = (status_next == ST_OK);
    for (int i = 0; i < DEPTH; i++) begin
      sh_mask_next[i] = (32'(i) >= 32'(idx));
    end
    removed_next = (ok_next && req.op != OP_INSERT) ? entries[idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      lt_mask <= lt_mask_next;
      sh_mask <= sh_mask_next;
      ok      <= ok_next;
      status  <= status_next;
      removed <= removed_next;
    end
  end

  // Each cell sees only its neighbors and the new value: the cell below for an insert and the
  // cell above for a removal.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] below;
    logic signed [VALUE_W-1:0] above;
    logic                      below_lt;

    if (g == 0) begin : g_first
      assign below    = req.value;
      assign below_lt = 1'b1;
    end else begin : g_rest
      assign below    = entries[g-1];
      assign below_lt = lt_mask[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above = entries[g];
    end else begin : g_inner
      assign above = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply && ok) begin
        if (req.op == OP_INSERT) begin
          if (!lt_mask[g]) begin
            entries[g] <= below_lt ? req.value : below;
          end
        end else if (sh_mask[g]) begin
          entries[g] <= above;
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ok) begin
      count_next = (req.op == OP_INSERT) ? count + CNT_W'(1) : count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      result.status        <= status;
      result.removed_value <= removed;
      result.entry_count   <= COUNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("entry count exceeds the list depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |=> $stable(count))
    else $error("entry count changed outside the apply step");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.reply && result.status == ST_FULL) |-> (32'(count) == 32'(DEPTH)))
    else $error("full status reported while the list has room");

endmodule

// ===== src/sorted_list_insert_remove_top.sv =====
// Sorted list top level: one transaction in on start, one result out on done.
//
// Holds up to DEPTH signed 32-bit values in ascending order. Each transaction
// is an insert or one of three removals and returns exactly one result: a
// status, the removed value (zero unless a removal succeeded) and the entry
// count afterwards. A transaction is accepted at a clock edge where start is
// high and busy is low. Its result is on the result port for one cycle with
// done high; the receiver must take it then. Each transaction runs through
// three steps: compare all entries against the request, shift the entry
// cells and update the count, and present the result. A new transaction may
// be accepted while the result is presented. Entries need no clearing after
// reset; the list starts empty.
`timescale 1ns / 1ps

module sorted_list_insert_remove_top
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  ctl_cmd_t cmd;

  sli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  sli_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted list block: directed and random transactions.
`timescale 1ns / 1ps

module testbench;
  import sli_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  // Shadow copy of the list contents, updated in the order transactions are accepted.
  logic signed [VALUE_W-1:0] shadow_entries [DEPTH];
  int                        shadow_count;
  result_t                   expected_results [$];
  int                        mismatch_count;
  bit                        idle_enable;

  sorted_list_insert_remove_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sorted_list_insert_remove_top regression: fail");
    $finish;
  end

  function automatic result_t predict_list_op(request_t req);
    result_t res;
    int      slot;
    res.status        = ST_OK;
    res.removed_value = '0;
    if (req.op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // The bound is tested before each read, and ties go in front of equal entries.
        slot = 0;
        while (slot < shadow_count && $signed(shadow_entries[slot]) < $signed(req.value))
          slot++;
        for (int k = shadow_count; k > slot; k--)
          shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[slot] = req.value;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      if (req.op == OP_REMOVE_AT) begin
        slot = int'(req.position);
      end else if (req.op == OP_REMOVE_FIRST) begin
        slot = 0;
      end else begin
        slot = shadow_count - 1;
      end
      if (slot >= shadow_count) begin
        res.status = ST_BADPOS;
      end else begin
        res.removed_value = shadow_entries[slot];
        for (int k = slot; k + 1 < shadow_count; k++)
          shadow_entries[k] = shadow_entries[k+1];
        shadow_count--;
      end
    end
    res.entry_count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // Starts one transaction, holding start until the block accepts it.
  task automatic send_request(input request_t item);
    if (idle_enable && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_list_op(item));
  endtask

  function automatic request_t make_request(op_e_t op, logic signed [VALUE_W-1:0] value,
                                            logic [POS_W-1:0] position);
    request_t req;
    req.op       = op;
    req.value    = value;
    req.position = position;
    return req;
  endfunction

  function automatic request_t random_request(int insert_pct);
    request_t req;
    if ($urandom_range(99) < insert_pct) begin
      req.op = OP_INSERT;
    end else begin
      req.op = op_e_t'($urandom_range(1, 3));
    end
    case ($urandom_range(3))
      0: req.value = int'($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(3))
          0: req.value = 32'sh8000_0000;
          1: req.value = 32'sh7fff_ffff;
          2: req.value = '0;
          default: req.value = -1;
        endcase
      end
      default: req.value = $urandom;
    endcase
    // Half the removals aim at a valid slot so that most of them succeed.
    if (shadow_count > 0 && $urandom_range(1) == 1) begin
      req.position = POS_W'($urandom_range(shadow_count - 1));
    end else begin
      req.position = POS_W'($urandom_range(15));
    end
    return req;
  endfunction

  task automatic report_field(input string name, input longint exp_val,
                              input longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d, removed %0d, count %0d", $time,
                 result.status, result.removed_value, result.entry_count);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        report_field("status", exp_res.status, result.status);
        report_field("removed_value", exp_res.removed_value, result.removed_value);
        report_field("entry_count", exp_res.entry_count, result.entry_count);
      end
    end
  end

  task automatic test_empty_removals();
    send_request(make_request(OP_REMOVE_FIRST, 32'sd5, 4'd0));
    send_request(make_request(OP_REMOVE_LAST, -32'sd1, 4'd15));
    send_request(make_request(OP_REMOVE_AT, 32'sh7fff_ffff, 4'd15));
    send_request(make_request(OP_REMOVE_AT, 32'sd0, 4'd0));
  endtask

  task automatic test_extremes_and_ties();
    send_request(make_request(OP_INSERT, 32'sh7fff_ffff, 4'd15));
    send_request(make_request(OP_INSERT, 32'sh8000_0000, 4'd0));
    send_request(make_request(OP_INSERT, 32'sd0, 4'd0));
    send_request(make_request(OP_INSERT, 32'sd0, 4'd15));
    send_request(make_request(OP_INSERT, -32'sd1, 4'd0));
    send_request(make_request(OP_INSERT, 32'sh7fff_ffff, 4'd0));
    send_request(make_request(OP_REMOVE_AT, 32'sd0, 4'd6));
    send_request(make_request(OP_REMOVE_AT, 32'sd0, 4'd15));
    send_request(make_request(OP_REMOVE_AT, -32'sd1, 4'd2));
    send_request(make_request(OP_REMOVE_AT, 32'sd0, 4'd4));
    send_request(make_request(OP_REMOVE_FIRST, 32'sd9, 4'd3));
    send_request(make_request(OP_REMOVE_LAST, 32'sd0, 4'd7));
    send_request(make_request(OP_REMOVE_LAST, 32'sd0, 4'd0));
    send_request(make_request(OP_REMOVE_FIRST, 32'sd0, 4'd0));
  endtask

  task automatic run_random_phase(input int items, input int insert_pct);
    repeat (items) send_request(random_request(insert_pct));
  endtask

  task automatic test_fill_and_drain();
    // Insert-heavy phases reach a full list, remove-heavy ones empty it again.
    repeat (10) begin
      run_random_phase(40, 85);
      run_random_phase(40, 15);
      run_random_phase(30, 50);
    end
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    run_random_phase(80, 80);
    run_random_phase(70, 30);
    idle_enable = 1'b1;
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    shadow_count   = 0;
    mismatch_count = 0;
    idle_enable    = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_removals();
    test_extremes_and_ties();
    test_fill_and_drain();
    test_back_to_back();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_list_insert_remove_top regression: pass");
    end else begin
      $display("sorted_list_insert_remove_top regression: fail");
    end
    $finish;
  end

endmodule
